### rtl/core/min_heap_sort_engine_assert.svh
// Assertion macros used by the block's monitor.
`ifndef MIN_HEAP_SORT_ENGINE_ASSERT_SVH
`define MIN_HEAP_SORT_ENGINE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MHSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MHSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/mhse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhse_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SD_RD,
        ST_SD_CMP,
        ST_SD_END,
        ST_SW_RD,
        ST_SW_WR,
        ST_EM_RD,
        ST_EM_CAP,
        ST_EM_HOLD
    } t_state;

    typedef enum logic {
        PH_BUILD,
        PH_SORT
    } t_phase;

endpackage

`default_nettype wire

### rtl/core/mhse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mhse_ram #(
    parameter int DEPTH = mhse_pkg::CAPACITY_DEF,
    parameter int AW    = 6
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire mhse_pkg::t_data i_wdata,
    input  wire logic [AW-1:0]  i_raddr0,
    input  wire logic [AW-1:0]  i_raddr1,
    output mhse_pkg::t_data     o_rdata0,
    output mhse_pkg::t_data     o_rdata1
);
    import mhse_pkg::*;

    t_data r_mem [DEPTH];
    t_data r_rdata0;
    t_data r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

`default_nettype wire

### rtl/core/mhse_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module mhse_seq #(
    parameter int CAPACITY = mhse_pkg::CAPACITY_DEF,
    parameter int AW       = 6,
    parameter int CW       = 7
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_emit_heap_only,
    // load side
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mhse_pkg::t_data i_in_value,
    input  wire logic           i_in_last,
    // heap store
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output mhse_pkg::t_data     o_wdata,
    output logic [AW-1:0]       o_raddr0,
    output logic [AW-1:0]       o_raddr1,
    input  wire mhse_pkg::t_data i_rdata0,
    input  wire mhse_pkg::t_data i_rdata1,
    // result side
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mhse_pkg::t_data     o_out_value,
    output logic                o_out_last,
    output logic                o_out_ovf
);
    import mhse_pkg::*;

    localparam int PW = CW + 1;

    t_state         r_state,  n_state;
    t_phase         r_phase,  n_phase;
    logic [CW-1:0]  r_count,  n_count;
    logic           r_ovf,    n_ovf;
    logic [CW-1:0]  r_parent, n_parent;
    logic [CW-1:0]  r_size,   n_size;
    logic [CW-1:0]  r_pos,    n_pos;
    logic [CW-1:0]  r_k,      n_k;
    t_data          r_cur,    n_cur;
    t_data          r_out_value, n_out_value;
    logic           r_out_last,  n_out_last;

    logic [PW-1:0]  w_left;
    logic [PW-1:0]  w_left_m1;
    logic [PW-1:0]  w_size_ext;
    logic [CW-1:0]  w_pos_m1;
    logic [CW-1:0]  w_size_m1;
    logic [CW-1:0]  w_cnt_nxt;
    logic           w_room;
    logic           w_right_ok;
    logic           w_lt_left;
    logic           w_lt_right;
    t_data          w_best_val;

    assign w_left     = {r_pos, 1'b0};
    assign w_left_m1  = w_left - PW'(1);
    assign w_size_ext = {1'b0, r_size};
    assign w_pos_m1   = r_pos - CW'(1);
    assign w_size_m1  = r_size - CW'(1);
    assign w_room     = (r_count < CW'(CAPACITY));
    assign w_cnt_nxt  = w_room ? (r_count + CW'(1)) : r_count;

    // compare unit: sifted value against left child, then winner against right
    assign w_right_ok = (w_left < w_size_ext);
    assign w_lt_left  = (i_rdata0 < r_cur);
    assign w_best_val = w_lt_left ? i_rdata0 : r_cur;
    assign w_lt_right = w_right_ok && (i_rdata1 < w_best_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_phase <= PH_BUILD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_parent    <= n_parent;
        r_size      <= n_size;
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_parent    = r_parent;
        n_size      = r_size;
        n_pos       = r_pos;
        n_k         = r_k;
        n_cur       = r_cur;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_in_ready  = 1'b0;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_raddr0    = '0;
        o_raddr1    = '0;

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (w_room) begin
                        o_we    = 1'b1;
                        o_waddr = r_count[AW-1:0];
                        o_wdata = i_in_value;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = w_cnt_nxt;
                    if (i_in_last) begin
                        n_phase  = PH_BUILD;
                        n_size   = w_cnt_nxt;
                        n_parent = w_cnt_nxt >> 1;
                        n_state  = ST_BLD_RD;
                    end
                end
            end
            ST_BLD_RD: begin
                if (r_parent == '0) begin
                    n_k = '0;
                    if (i_emit_heap_only) begin
                        n_state = ST_EM_RD;
                    end else begin
                        n_phase = PH_SORT;
                        n_state = ST_SW_RD;
                    end
                end else begin
                    o_raddr0 = AW'(r_parent - CW'(1));
                    n_state  = ST_BLD_LD;
                end
            end
            ST_BLD_LD: begin
                n_cur   = i_rdata0;
                n_pos   = r_parent;
                n_state = ST_SD_RD;
            end
            ST_SD_RD: begin
                if (w_left > w_size_ext) begin
                    n_state = ST_SD_END;
                end else begin
                    o_raddr0 = w_left_m1[AW-1:0];
                    o_raddr1 = w_left[AW-1:0];
                    n_state  = ST_SD_CMP;
                end
            end
            ST_SD_CMP: begin
                if (w_lt_left || w_lt_right) begin
                    // move the smaller child up, keep sifting from its slot
                    o_we    = 1'b1;
                    o_waddr = w_pos_m1[AW-1:0];
                    if (w_lt_right) begin
                        o_wdata = i_rdata1;
                        n_pos   = w_left[CW-1:0] + CW'(1);
                    end else begin
                        o_wdata = i_rdata0;
                        n_pos   = w_left[CW-1:0];
                    end
                    n_state = ST_SD_RD;
                end else begin
                    n_state = ST_SD_END;
                end
            end
            ST_SD_END: begin
                o_we    = 1'b1;
                o_waddr = w_pos_m1[AW-1:0];
                o_wdata = r_cur;
                if (r_phase == PH_BUILD) begin
                    n_parent = r_parent - CW'(1);
                    n_state  = ST_BLD_RD;
                end else begin
                    n_state = ST_SW_RD;
                end
            end
            ST_SW_RD: begin
                if (r_size > CW'(1)) begin
                    o_raddr0 = '0;
                    o_raddr1 = w_size_m1[AW-1:0];
                    n_state  = ST_SW_WR;
                end else begin
                    n_k     = '0;
                    n_state = ST_EM_RD;
                end
            end
            ST_SW_WR: begin
                // old root goes to the tail, old tail sifts down from the root
                o_we    = 1'b1;
                o_waddr = w_size_m1[AW-1:0];
                o_wdata = i_rdata0;
                n_cur   = i_rdata1;
                n_pos   = CW'(1);
                n_size  = w_size_m1;
                n_state = ST_SD_RD;
            end
            ST_EM_RD: begin
                o_raddr0 = r_k[AW-1:0];
                n_state  = ST_EM_CAP;
            end
            ST_EM_CAP: begin
                n_out_value = i_rdata0;
                n_out_last  = ((r_k + CW'(1)) == r_count);
                n_state     = ST_EM_HOLD;
            end
            ST_EM_HOLD: begin
                if (i_out_ready) begin
                    if (r_out_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_out_valid = (r_state == ST_EM_HOLD);
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_ovf;

endmodule

`default_nettype wire

### rtl/core/min_heap_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Min-heap sort engine. Signed 32-bit values stream in one per cycle until a
// transaction with tlast; values beyond CAPACITY are dropped and reported on
// o_m_axis_tuser of every result of that run. The engine then builds a min-heap
// in place (Floyd, bottom-up) and, unless the emit_heap_only bit is set, runs
// heapsort, and finally streams the array in index order (descending when
// sorted), with tlast on the final result. While building, sorting and
// emitting the input is not ready. Each sift-down level reads the children
// from the two-read-port heap store, then compares and moves. Each result is
// read through the store's registered port into the output register and held
// until taken; the next read starts only after that. The store needs no clear
// after reset: only entries of the current set are used.
module min_heap_sort_engine #(
    parameter int CAPACITY = mhse_pkg::CAPACITY_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_wr_data,   // emit_heap_only
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [mhse_pkg::DATA_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  wire logic                        i_s_axis_tlast,  // is_last
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [mhse_pkg::DATA_W-1:0]      o_m_axis_tdata,  // [31:0] value_res
    output logic                             o_m_axis_tlast,  // is_last_res
    output logic [0:0]                       o_m_axis_tuser   // [0] overflow
);
    import mhse_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic           r_emit_heap_only;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    t_data          w_wdata;
    logic [AW-1:0]  w_raddr0;
    logic [AW-1:0]  w_raddr1;
    t_data          w_rdata0;
    t_data          w_rdata1;
    t_data          w_out_value;
    logic           w_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_heap_only <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_emit_heap_only <= i_cfg_wr_data;
        end
    end

    mhse_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_emit_heap_only (r_emit_heap_only),
        .i_in_valid       (i_s_axis_tvalid),
        .o_in_ready       (o_s_axis_tready),
        .i_in_value       (t_data'(i_s_axis_tdata)),
        .i_in_last        (i_s_axis_tlast),
        .o_we             (w_we),
        .o_waddr          (w_waddr),
        .o_wdata          (w_wdata),
        .o_raddr0         (w_raddr0),
        .o_raddr1         (w_raddr1),
        .i_rdata0         (w_rdata0),
        .i_rdata1         (w_rdata1),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out_value      (w_out_value),
        .o_out_last       (o_m_axis_tlast),
        .o_out_ovf        (w_out_ovf)
    );

    mhse_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rdata0),
        .o_rdata1 (w_rdata1)
    );

    assign o_m_axis_tdata = w_out_value;
    assign o_m_axis_tuser = w_out_ovf;

endmodule

`default_nettype wire

### rtl/core/mhse_mon.sv
`timescale 1ns / 1ps
`default_nettype none

`include "min_heap_sort_engine_assert.svh"

module mhse_mon (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_axis_tvalid,
    input wire logic                        o_s_axis_tready,
    input wire logic                        i_s_axis_tlast,
    input wire logic                        o_m_axis_tvalid,
    input wire logic                        i_m_axis_tready,
    input wire logic [mhse_pkg::DATA_W-1:0] o_m_axis_tdata,
    input wire logic                        o_m_axis_tlast,
    input wire logic [0:0]                  o_m_axis_tuser
);

    // hold a stalled result
    `MHSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser), "stalled result changed")

    // never load while a result is on offer
    `MHSE_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready, "input ready while emitting")

    // drop ready right after the closing input transaction
    `MHSE_ASSERT_NEXT(a_busy_after_last, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready && !o_m_axis_tvalid, "not busy after last input")

    // return to loading once the final result is taken
    `MHSE_ASSERT_NEXT(a_ready_after_run, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, o_s_axis_tready, "not ready after run")

endmodule

bind min_heap_sort_engine mhse_mon u_mon (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

### tb/tb_min_heap_sort_engine.sv
`timescale 1ns / 1ps

module tb_min_heap_sort_engine;

    import mhse_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int LIMIT      = 500000;
    localparam int RAND_BEATS = 460;

    localparam bit MODE_SORTED = 1'b0;
    localparam bit MODE_HEAP   = 1'b1;

    typedef enum int {
        VAL_WIDE,
        VAL_CLUSTER,
        VAL_EDGE
    } t_value_mix;

    typedef struct packed {
        t_data value;
        logic  last;
    } t_load_beat;

    typedef struct {
        t_data value;
        bit    last;
        bit    ovf;
    } t_out_word;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_wr_en     = 1'b0;
    logic                 i_cfg_wr_data   = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [DATA_W-1:0]    i_s_axis_tdata  = '0;  // [31:0] value
    logic                 i_s_axis_tlast  = 1'b0; // is_last
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    o_m_axis_tdata;         // [31:0] value_res
    logic                 o_m_axis_tlast;         // is_last_res
    logic [0:0]           o_m_axis_tuser;         // [0] overflow

    min_heap_sort_engine #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    t_load_beat load_q[$];
    t_out_word  out_words_q[$];
    t_load_beat next_beat;
    t_out_word  got_word;

    int beats_queued   = 0;
    int beats_accepted = 0;
    int mismatches     = 0;
    int cycles         = 0;
    int idle_pct       = 24;
    bit beat_taken     = 1'b0;

    // Mirror of the block: set being loaded, its overflow flag and the mode bit
    t_data heap_img [1:CAP];
    int    set_count     = 0;
    bit    set_ovf       = 1'b0;
    bit    heap_only_cfg = MODE_SORTED;

    function automatic void heap_sift_down(int start, int size);
        int    pos;
        int    lc;
        int    rc;
        int    best;
        t_data tmp;
        pos = start;
        while (1) begin
            lc   = 2 * pos;
            rc   = lc + 1;
            best = pos;
            if (lc > size)
                break;
            // strict compare: the left child wins a tie
            if (heap_img[pos] > heap_img[lc])
                best = lc;
            if (rc <= size && heap_img[best] > heap_img[rc])
                best = rc;
            if (best == pos)
                break;
            tmp            = heap_img[pos];
            heap_img[pos]  = heap_img[best];
            heap_img[best] = tmp;
            pos            = best;
        end
    endfunction

    function automatic void absorb_value(t_data v, bit last);
        int        n;
        int        k;
        t_data     tmp;
        t_out_word w;
        if (set_count < CAP) begin
            set_count++;
            heap_img[set_count] = v;
        end else begin
            set_ovf = 1'b1;
        end
        if (!last)
            return;
        n = set_count;
        for (k = n / 2; k > 0; k--)
            heap_sift_down(k, n);
        if (heap_only_cfg == MODE_SORTED) begin
            for (k = n; k > 1; k--) begin
                tmp         = heap_img[1];
                heap_img[1] = heap_img[k];
                heap_img[k] = tmp;
                heap_sift_down(1, k - 1);
            end
        end
        for (k = 1; k <= n; k++) begin
            w.value = heap_img[k];
            w.last  = (k == n);
            w.ovf   = set_ovf;
            out_words_q.push_back(w);
        end
        set_count = 0;
        set_ovf   = 1'b0;
    endfunction

    function automatic t_data pick_value(t_value_mix mix);
        int    r;
        t_data v;
        r = $urandom_range(0, 9);
        case (mix)
            VAL_CLUSTER: v = t_data'(int'($urandom_range(0, 12)) - 6);
            VAL_EDGE: begin
                case (r)
                    0, 1:    v = {1'b1, 31'd0};
                    2, 3:    v = {1'b0, {31{1'b1}}};
                    4:       v = '0;
                    5:       v = '1;
                    6:       v = 32'sd1;
                    default: v = t_data'($urandom);
                endcase
            end
            default: v = t_data'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_beat(t_data v, bit last);
        t_load_beat b;
        b.value = v;
        b.last  = last;
        load_q.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_set(int len, t_value_mix mix);
        for (int k = 0; k < len; k++)
            push_beat(pick_value(mix), k == len - 1);
    endtask

    // Hold off until every load is taken and every result is out, then let
    // the block settle before touching the mode bit.
    task automatic wait_drained();
        while (beats_accepted != beats_queued || out_words_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(bit mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        heap_only_cfg = mode;
    endtask

    // Input side: predict on every accepted transaction
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        beat_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            absorb_value(t_data'(i_s_axis_tdata), i_s_axis_tlast);
            beats_accepted <= beats_accepted + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || beat_taken) begin
            if (load_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_beat = load_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_beat.value;
                i_s_axis_tlast  <= next_beat.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Output side: compare each transaction with the oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (out_words_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual value %0d last %0b",
                         $time, $signed(o_m_axis_tdata), o_m_axis_tlast);
            end else begin
                got_word = out_words_q.pop_front();
                if (o_m_axis_tdata !== got_word.value) begin
                    mismatches++;
                    $display("%0t: value_res: expected %0d, actual %0d", $time,
                             got_word.value, $signed(o_m_axis_tdata));
                end
                if (o_m_axis_tlast !== got_word.last) begin
                    mismatches++;
                    $display("%0t: is_last_res: expected %0b, actual %0b", $time,
                             got_word.last, o_m_axis_tlast);
                end
                if (o_m_axis_tuser[0] !== got_word.ovf) begin
                    mismatches++;
                    $display("%0t: overflow: expected %0b, actual %0b", $time,
                             got_word.ovf, o_m_axis_tuser[0]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles == LIMIT) begin
            $display("min_heap_sort_engine: mismatch");
            $finish;
        end
    end

    initial begin
        int         phase;
        int         phase_beats;
        int         len;
        int         r;
        int         target;
        t_value_mix mix;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single element, extremes and ties, then ties and extremes in heap mode
        write_mode(MODE_SORTED);
        push_beat({1'b1, 31'd0}, 1'b1);
        push_beat({1'b0, {31{1'b1}}}, 1'b0);
        push_beat({1'b1, 31'd0}, 1'b0);
        push_beat('0, 1'b0);
        push_beat('1, 1'b0);
        push_beat(32'sd1, 1'b0);
        push_beat({1'b0, {31{1'b1}}}, 1'b0);
        push_beat({1'b1, 31'd0}, 1'b0);
        push_beat(32'sd5, 1'b1);
        push_beat(32'sd3, 1'b0);
        push_beat(32'sd1, 1'b0);
        push_beat(32'sd1, 1'b0);
        push_beat(32'sd2, 1'b0);
        push_beat(32'sd2, 1'b1);

        write_mode(MODE_HEAP);
        push_beat(32'sd7, 1'b0);
        push_beat(-32'sd3, 1'b0);
        push_beat(32'sd7, 1'b0);
        push_beat(-32'sd3, 1'b0);
        push_beat('0, 1'b0);
        push_beat(32'sd9, 1'b1);
        push_beat({1'b0, {31{1'b1}}}, 1'b0);
        push_beat({1'b1, 31'd0}, 1'b1);

        // Random phases alternate the mode; the third runs with no idling
        target = beats_queued + RAND_BEATS;
        phase  = 0;
        while (beats_queued < target) begin
            write_mode(phase[0] ? MODE_HEAP : MODE_SORTED);
            idle_pct    = (phase == 2) ? 0 : 24;
            phase_beats = 0;
            while (phase_beats < 70 && beats_queued < target) begin
                r = $urandom_range(0, 99);
                if (phase_beats == 0 && phase < 3)
                    len = (phase == 0) ? CAP + 1 : (phase == 1) ? CAP + 6 : CAP;
                else if (r < 70)
                    len = $urandom_range(1, 12);
                else if (r < 88)
                    len = $urandom_range(13, 40);
                else if (r < 94)
                    len = CAP;
                else
                    len = $urandom_range(CAP + 1, CAP + 8);
                mix = t_value_mix'($urandom_range(0, 2));
                queue_set(len, mix);
                phase_beats += len;
            end
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && out_words_q.size() == 0) begin
            $display("min_heap_sort_engine: match");
        end else begin
            $display("min_heap_sort_engine: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mhse_pkg.sv
rtl/core/mhse_ram.sv
rtl/core/mhse_seq.sv
rtl/core/min_heap_sort_engine.sv
rtl/core/mhse_mon.sv
tb/tb_min_heap_sort_engine.sv
